// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SAKVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
// Next-cycle implication.
`define SAKVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define SAKVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SAKVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/sakvt_pkg.sv =====
`default_nettype none
package sakvt_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int TOL_BITS       = 31;

	localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);

	localparam logic REQ_SET    = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_APPENDED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_FULL      = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] key;
		logic        [31:0] value;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic active;
		logic lookup;
		logic full;
		logic hit;
		logic appended;
	} tok_ctl_t;

endpackage
`default_nettype wire

// ===== src/sakvt_cell.sv =====
`default_nettype none
module sakvt_cell #(
	parameter int IDX        = 0,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int CNT_W      = 5
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  [CNT_W-1:0]               count,
	input  wire  [sakvt_pkg::TOL_BITS-1:0] tolerance,
	input  sakvt_pkg::tok_ctl_t            ctl_in,
	input  wire  [KEY_BITS-1:0]            key_in,
	input  wire  [VALUE_BITS-1:0]          value_in,
	input  wire  [VALUE_BITS-1:0]          rd_in,
	output sakvt_pkg::tok_ctl_t            ctl_out,
	output logic [KEY_BITS-1:0]            key_out,
	output logic [VALUE_BITS-1:0]          value_out,
	output logic [VALUE_BITS-1:0]          rd_out
);
	import sakvt_pkg::*;

	localparam int CMP_W = (KEY_BITS + 1 > TOL_BITS) ? KEY_BITS + 1 : TOL_BITS;

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	tok_ctl_t              ctl_q;
	logic [KEY_BITS-1:0]   key_out_q;
	logic [VALUE_BITS-1:0] val_out_q;
	logic [VALUE_BITS-1:0] rd_q;

	logic [KEY_BITS:0] diff;
	logic [KEY_BITS:0] mag;
	logic              occupied;
	logic              match;
	logic              take;
	logic              hit_here;
	logic              app_here;
	tok_ctl_t          ctl_nxt;

	always_comb begin
		diff     = {key_q[KEY_BITS-1], key_q} - {key_in[KEY_BITS-1], key_in};
		mag      = diff[KEY_BITS] ? (~diff + (KEY_BITS+1)'(1)) : diff;
		occupied = CNT_W'(IDX) < count;
		match    = occupied && (CMP_W'(mag) < CMP_W'(tolerance));
		take     = ctl_in.active && !ctl_in.full && !ctl_in.hit && !ctl_in.appended;
		hit_here = take && match;
		app_here = take && (ctl_in.lookup == REQ_SET) && (CNT_W'(IDX) == count);
		ctl_nxt          = ctl_in;
		ctl_nxt.hit      = ctl_in.hit | hit_here;
		ctl_nxt.appended = ctl_in.appended | app_here;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		key_out_q <= key_in;
		val_out_q <= value_in;
		rd_q      <= (hit_here && ctl_in.lookup == REQ_LOOKUP) ? val_q : rd_in;
		if (app_here) begin
			key_q <= key_in;
		end
		if (app_here || (hit_here && ctl_in.lookup == REQ_SET)) begin
			val_q <= value_in;
		end
	end

	assign ctl_out   = ctl_q;
	assign key_out   = key_out_q;
	assign value_out = val_out_q;
	assign rd_out    = rd_q;

endmodule
`default_nettype wire

// ===== src/small_associative_key_value_table.sv =====
// A request passes through the ENTRIES cell registers, then the pending
// response register and the output register; it waits in the pending
// register while a previous response is held. Only one request is in
// flight at a time: the request walks the cell chain one cell per cycle
// and the next is taken once the response reaches the output register.
// Reset: asynchronous, active low; clears the entry count and sets the
// match tolerance to 1. Stored keys and values are not cleared.
`default_nettype none
`include "assert_macros.svh"
module small_associative_key_value_table #(
	parameter int ENTRIES    = sakvt_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = sakvt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = sakvt_pkg::VALUE_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            req_valid,
	output logic                           req_ready,
	input  sakvt_pkg::req_t                req,
	output logic                           rsp_valid,
	input  wire                            rsp_ready,
	output sakvt_pkg::rsp_t                rsp,
	input  wire                            cfg_we,
	input  wire  [sakvt_pkg::TOL_BITS-1:0] cfg_wdata
);
	import sakvt_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic [TOL_BITS-1:0] tol_q;
	logic [CNT_W-1:0]    count_q;
	logic                busy_q;
	logic                pend_valid_q;
	rsp_t                pend_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	tok_ctl_t              ctl_w [0:ENTRIES];
	logic [KEY_BITS-1:0]   key_w [0:ENTRIES];
	logic [VALUE_BITS-1:0] val_w [0:ENTRIES];
	logic [VALUE_BITS-1:0] rd_w  [0:ENTRIES];

	logic     accept;
	logic     full;
	logic     move;
	tok_ctl_t ctl_end;
	rsp_t     result;

	always_comb begin
		accept           = req_valid && req_ready;
		full             = count_q == CNT_W'(ENTRIES);
		ctl_w[0].active   = accept;
		ctl_w[0].lookup   = req.req_type;
		ctl_w[0].full     = (req.req_type == REQ_SET) && full;
		ctl_w[0].hit      = 1'b0;
		ctl_w[0].appended = 1'b0;
		key_w[0]         = KEY_BITS'(req.key);
		val_w[0]         = VALUE_BITS'(req.value);
		rd_w[0]          = '0;
	end

	assign req_ready = !busy_q;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		sakvt_cell #(
			.IDX        (i),
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.count     (count_q),
			.tolerance (tol_q),
			.ctl_in    (ctl_w[i]),
			.key_in    (key_w[i]),
			.value_in  (val_w[i]),
			.rd_in     (rd_w[i]),
			.ctl_out   (ctl_w[i+1]),
			.key_out   (key_w[i+1]),
			.value_out (val_w[i+1]),
			.rd_out    (rd_w[i+1])
		);
	end

	always_comb begin
		ctl_end           = ctl_w[ENTRIES];
		result.read_value = 32'(rd_w[ENTRIES]);
		if (ctl_end.full) begin
			result.status = ST_FULL;
		end else if (ctl_end.lookup == REQ_LOOKUP) begin
			result.status = ctl_end.hit ? ST_FOUND : ST_NOT_FOUND;
		end else begin
			result.status = ctl_end.hit ? ST_UPDATED : ST_APPENDED;
		end
		move = pend_valid_q && (!rsp_valid_q || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q        <= TOL_RESET;
			count_q      <= '0;
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (ctl_end.active && ctl_end.appended) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (ctl_end.active) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end
			if (move) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the finished response until the output register frees
	always_ff @(posedge clk) begin
		if (ctl_end.active) begin
			pend_q <= result;
		end
		if (move) begin
			rsp_q <= pend_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SAKVT_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(ENTRIES))
	`SAKVT_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, busy_q)
	`SAKVT_ASSERT_IMP(a_end_in_flight, clk, arst_n, ctl_end.active, busy_q && !pend_valid_q)
	`SAKVT_ASSERT_IMP(a_append_room, clk, arst_n, ctl_end.active && ctl_end.appended, !full)

endmodule
`default_nettype wire
